/* rtl/core/spim_pkg.sv */
// Shared types and constants for the SPI master byte-transfer core.
`default_nettype none

package spim_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd2;

	localparam logic [1:0]  SPI_MODE_RST    = 2'd0;
	localparam logic        LSB_FIRST_RST   = 1'b0;
	localparam logic [15:0] HALF_PERIOD_RST = 16'd10;

	typedef struct packed {
		logic [1:0]  spi_mode;
		logic        lsb_first;
		logic [15:0] half_period_ticks;
	} spim_cfg_t;

	// one tick as it sits in the queue, already classified
	typedef struct packed {
		logic       is_start;
		logic [7:0] tx_byte;
		logic [3:0] select_line;
		logic       end_of_burst;
		logic       miso_level;
	} spim_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} spim_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/spim_front.sv */
// Front end: takes input ticks, qualifies start requests and pushes them into the queue.
`default_nettype none

module spim_front
	import spim_pkg::*;
#(
	parameter int NUM_SELECT = 16
) (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  tx_byte,
	input  wire logic [3:0]  select_line,
	input  wire logic        end_of_burst,
	input  wire logic        miso_level,
	input  wire spim_qstat_t qstat,
	output logic             push,
	output spim_item_t       item
);

	logic line_ok;

	// a start on a line that does not exist is just a plain tick
	assign line_ok = {1'b0, select_line} < 5'(NUM_SELECT);

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	always_comb begin
		item.is_start     = action && line_ok;
		item.tx_byte      = tx_byte;
		item.select_line  = select_line;
		item.end_of_burst = end_of_burst;
		item.miso_level   = miso_level;
	end

endmodule

`default_nettype wire

/* rtl/core/spim_queue.sv */
// Short FIFO between the front end and the transfer engine.
`default_nettype none

module spim_queue
	import spim_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire spim_item_t wr_item,
	input  wire logic       pop,
	output spim_item_t      rd_item,
	output spim_qstat_t     qstat
);

	spim_item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;
	logic [QCNT_W-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign rd_item     = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

`default_nettype wire

/* rtl/core/spim_engine.sv */
// Transfer engine: advances the SPI bit timing one tick per queued item.
`default_nettype none

module spim_engine
	import spim_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire spim_cfg_t   cfg,
	input  wire spim_item_t  item,
	input  wire spim_qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             sclk_level,
	output logic             mosi_level,
	output logic             mosi_drive,
	output logic [15:0]      select_levels,
	output logic             busy_flag,
	output logic             byte_done,
	output logic [7:0]       rx_byte
);

	typedef struct packed {
		logic        active;
		logic [4:0]  edge_count;
		logic [15:0] tick_timer;
		logic [7:0]  out_shift;
		logic [7:0]  in_shift;
		logic [3:0]  chosen_line;
		logic        release_when_done;
		logic        clock_pin;
		logic        data_pin;
		logic        data_pin_enable;
		logic [15:0] select_pins;
	} spim_state_t;

	spim_state_t st_q;
	spim_state_t nx;
	logic        done_d;
	logic [7:0]  rx_d;
	logic        out_valid_q;
	logic        pol;
	logic        pha;
	logic        leading;
	logic [15:0] timer_dec;
	logic [15:0] load_val;

	assign pol       = cfg.spi_mode[1];
	assign pha       = cfg.spi_mode[0];
	assign leading   = ~st_q.edge_count[0];
	assign timer_dec = st_q.tick_timer - 16'(st_q.tick_timer != 16'd0);
	assign load_val  = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;

	// output register frees up when empty or being taken
	assign pop = !qstat.empty && (!out_valid_q || !out_stall);

	always_comb begin
		nx     = st_q;
		done_d = 1'b0;
		rx_d   = 8'd0;
		if (st_q.active) begin
			nx.tick_timer = timer_dec;
			if (timer_dec == 16'd0) begin
				if (!st_q.edge_count[4]) begin
					nx.clock_pin = leading ? ~pol : pol;
					// shift edge when edge kind matches CPHA, else sample edge
					if (leading == pha) begin
						nx.data_pin  = cfg.lsb_first ? st_q.out_shift[0] : st_q.out_shift[7];
						nx.out_shift = cfg.lsb_first ? {1'b0, st_q.out_shift[7:1]}
						                             : {st_q.out_shift[6:0], 1'b0};
					end else begin
						nx.in_shift = cfg.lsb_first ? {item.miso_level, st_q.in_shift[7:1]}
						                            : {st_q.in_shift[6:0], item.miso_level};
					end
					nx.edge_count = st_q.edge_count + 5'd1;
					nx.tick_timer = load_val;
				end else begin
					nx.active     = 1'b0;
					nx.edge_count = 5'd0;
					done_d        = 1'b1;
					rx_d          = st_q.in_shift;
					if (st_q.release_when_done) begin
						nx.data_pin_enable = 1'b0;
						nx.select_pins     = st_q.select_pins | (16'd1 << st_q.chosen_line);
					end
				end
			end
		end else if (item.is_start) begin
			nx.active            = 1'b1;
			nx.edge_count        = 5'd0;
			nx.tick_timer        = load_val;
			nx.out_shift         = item.tx_byte;
			nx.in_shift          = 8'd0;
			nx.chosen_line       = item.select_line;
			nx.release_when_done = item.end_of_burst;
			nx.clock_pin         = pol;
			nx.select_pins       = st_q.select_pins & ~(16'd1 << item.select_line);
			nx.data_pin_enable   = 1'b1;
			if (!pha) begin
				nx.data_pin  = cfg.lsb_first ? item.tx_byte[0] : item.tx_byte[7];
				nx.out_shift = cfg.lsb_first ? {1'b0, item.tx_byte[7:1]}
				                             : {item.tx_byte[6:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.active            <= 1'b0;
			st_q.edge_count        <= 5'd0;
			st_q.tick_timer        <= 16'd0;
			st_q.out_shift         <= 8'd0;
			st_q.in_shift          <= 8'd0;
			st_q.chosen_line       <= 4'd0;
			st_q.release_when_done <= 1'b0;
			st_q.clock_pin         <= 1'b0;
			st_q.data_pin          <= 1'b0;
			st_q.data_pin_enable   <= 1'b0;
			st_q.select_pins       <= 16'hFFFF;
			out_valid_q            <= 1'b0;
		end else begin
			if (pop) begin
				st_q        <= nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sclk_level    <= nx.clock_pin;
			mosi_level    <= nx.data_pin_enable & nx.data_pin;
			mosi_drive    <= nx.data_pin_enable;
			select_levels <= nx.select_pins;
			busy_flag     <= nx.active;
			byte_done     <= done_d;
			rx_byte       <= rx_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/spi_master_byte_transfer_core.sv */
// Path: an accepted tick is written into the queue; the output register loads from the
// queue head when the queue is not empty and the output register is empty or being taken.
// Throughput: one tick per cycle while the output is not stalled; state updates per pop.
// A 4-entry queue sits between the input side and the engine, so the input keeps
// taking up to four ticks while a result waits at the output.
// Reset: transfer idle, all selects high, pins low, config back to mode 0, MSB first, 10.
`default_nettype none

module spi_master_byte_transfer_core
	import spim_pkg::*;
#(
	parameter int NUM_SELECT = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 action,
	input  wire logic [7:0]           tx_byte,
	input  wire logic [3:0]           select_line,
	input  wire logic                 end_of_burst,
	input  wire logic                 miso_level,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      sclk_level,
	output logic                      mosi_level,
	output logic                      mosi_drive,
	output logic [15:0]               select_levels,
	output logic                      busy_flag,
	output logic                      byte_done,
	output logic [7:0]                rx_byte
);

	spim_cfg_t   cfg_q;
	spim_qstat_t qstat;
	spim_item_t  push_item;
	spim_item_t  pop_item;
	logic        push;
	logic        pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spi_mode          <= SPI_MODE_RST;
			cfg_q.lsb_first         <= LSB_FIRST_RST;
			cfg_q.half_period_ticks <= HALF_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SPI_MODE:    cfg_q.spi_mode          <= cfg_data[1:0];
				CFG_LSB_FIRST:   cfg_q.lsb_first         <= cfg_data[0];
				CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	spim_front #(
		.NUM_SELECT(NUM_SELECT)
	) u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.tx_byte      (tx_byte),
		.select_line  (select_line),
		.end_of_burst (end_of_burst),
		.miso_level   (miso_level),
		.qstat        (qstat),
		.push         (push),
		.item         (push_item)
	);

	spim_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.rd_item (pop_item),
		.qstat   (qstat)
	);

	spim_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item          (pop_item),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sclk_level    (sclk_level),
		.mosi_level    (mosi_level),
		.mosi_drive    (mosi_drive),
		.select_levels (select_levels),
		.busy_flag     (busy_flag),
		.byte_done     (byte_done),
		.rx_byte       (rx_byte)
	);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_done |-> !busy_flag)
		else $error("byte_done reported while still busy");

	a_rx_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_done |-> rx_byte == 8'd0)
		else $error("rx_byte nonzero without byte_done");

	a_mosi_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mosi_drive |-> !mosi_level)
		else $error("mosi_level high while MOSI released");

	a_select_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && busy_flag |-> select_levels != 16'hFFFF)
		else $error("busy with no select line asserted");

endmodule

`default_nettype wire

/* dv/tb_spi_master_byte_transfer_core.sv */
// Self-checking testbench for the SPI master byte-transfer core: random ticks, per-tick pin check.
`default_nettype none

module tb_spi_master_byte_transfer_core
	import spim_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SEL = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 105;

	typedef struct packed {
		logic        sclk;
		logic        mosi;
		logic        mosi_oe;
		logic [15:0] sel;
		logic        busy;
		logic        done;
		logic [7:0]  rx;
	} pin_snapshot_t;

	// Tracks the pin state tick by tick and holds the pin snapshots still owed by the core.
	class spi_pin_tracker;
		logic [1:0]    mode;
		logic          lsb;
		logic [15:0]   half;
		logic          active;
		logic [4:0]    edge_cnt;
		logic [15:0]   timer;
		logic [7:0]    tx_sh;
		logic [7:0]    rx_sh;
		logic [3:0]    line_q;
		logic          release_q;
		logic          sclk_q;
		logic          mosi_q;
		logic          mosi_oe_q;
		logic [15:0]   sel_q;
		pin_snapshot_t pins_due[$];
		int            errors;

		function new();
			mode = SPI_MODE_RST;
			lsb = LSB_FIRST_RST;
			half = HALF_PERIOD_RST;
			active = 1'b0;
			edge_cnt = '0;
			timer = '0;
			tx_sh = '0;
			rx_sh = '0;
			line_q = '0;
			release_q = 1'b0;
			sclk_q = 1'b0;
			mosi_q = 1'b0;
			mosi_oe_q = 1'b0;
			sel_q = '1;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				CFG_SPI_MODE: mode = data[1:0];
				CFG_LSB_FIRST: lsb = data[0];
				CFG_HALF_PERIOD: half = data;
				default: ;
			endcase
		endfunction

		// zero half period behaves as one
		function logic [15:0] reload();
			return (half == 16'd0) ? 16'd1 : half;
		endfunction

		function void shift_out();
			mosi_q = lsb ? tx_sh[0] : tx_sh[7];
			tx_sh = lsb ? {1'b0, tx_sh[7:1]} : {tx_sh[6:0], 1'b0};
		endfunction

		function void note_tick(logic act, logic [7:0] tx, logic [3:0] line, logic eob,
				logic miso);
			pin_snapshot_t p;
			logic leading;
			p = '0;
			if (active) begin
				if (timer > 16'd0)
					timer--;
				if (timer == 16'd0) begin
					if (edge_cnt < 5'd16) begin
						leading = ~edge_cnt[0];
						sclk_q = leading ? ~mode[1] : mode[1];
						// CPHA picks which edge shifts and which samples
						if (leading == mode[0])
							shift_out();
						else
							rx_sh = lsb ? {miso, rx_sh[7:1]} : {rx_sh[6:0], miso};
						edge_cnt++;
						timer = reload();
					end else begin
						active = 1'b0;
						edge_cnt = '0;
						p.done = 1'b1;
						p.rx = rx_sh;
						if (release_q) begin
							mosi_oe_q = 1'b0;
							sel_q[line_q] = 1'b1;
						end
					end
				end
			end else if (act && int'(line) < NUM_SEL) begin
				active = 1'b1;
				edge_cnt = '0;
				timer = reload();
				tx_sh = tx;
				rx_sh = '0;
				line_q = line;
				release_q = eob;
				sclk_q = mode[1];
				sel_q[line] = 1'b0;
				mosi_oe_q = 1'b1;
				if (!mode[0])
					shift_out();
			end
			p.sclk = sclk_q;
			p.mosi = mosi_oe_q & mosi_q;
			p.mosi_oe = mosi_oe_q;
			p.sel = sel_q;
			p.busy = active;
			pins_due.push_back(p);
		endfunction

		function void compare(string nm, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected 0x%0h actual 0x%0h", $time, nm, want, got);
				errors++;
			end
		endfunction

		function void check_pins(pin_snapshot_t got);
			pin_snapshot_t want;
			if (pins_due.size() == 0) begin
				$display("%0t: result transaction with nothing expected", $time);
				errors++;
				return;
			end
			want = pins_due.pop_front();
			compare("sclk_level", want.sclk, got.sclk);
			compare("mosi_level", want.mosi, got.mosi);
			compare("mosi_drive", want.mosi_oe, got.mosi_oe);
			compare("select_levels", want.sel, got.sel);
			compare("busy_flag", want.busy, got.busy);
			compare("byte_done", want.done, got.done);
			compare("rx_byte", want.rx, got.rx);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SPI_MODE;
	logic [15:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 action = 1'b0;
	logic [7:0]           tx_byte = '0;
	logic [3:0]           select_line = '0;
	logic                 end_of_burst = 1'b0;
	logic                 miso_level = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 sclk_level;
	logic                 mosi_level;
	logic                 mosi_drive;
	logic [15:0]          select_levels;
	logic                 busy_flag;
	logic                 byte_done;
	logic [7:0]           rx_byte;

	spi_pin_tracker tracker;
	bit             gap_on = 1'b0;
	bit             stall_on = 1'b0;
	int             cycles = 0;

	spi_master_byte_transfer_core #(.NUM_SELECT(NUM_SEL)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.tx_byte(tx_byte),
		.select_line(select_line),
		.end_of_burst(end_of_burst),
		.miso_level(miso_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sclk_level(sclk_level),
		.mosi_level(mosi_level),
		.mosi_drive(mosi_drive),
		.select_levels(select_levels),
		.busy_flag(busy_flag),
		.byte_done(byte_done),
		.rx_byte(rx_byte)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_pins('{sclk: sclk_level, mosi: mosi_level, mosi_oe: mosi_drive,
				sel: select_levels, busy: busy_flag, done: byte_done, rx: rx_byte});
	end

	// receiver back-pressure in random bursts
	initial begin : stall_gen
		int n;
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_config(logic [1:0] m, logic l, logic [15:0] h);
		logic [CFG_IDX_W-1:0] regs[3] = '{CFG_SPI_MODE, CFG_LSB_FIRST, CFG_HALF_PERIOD};
		logic [15:0] vals[3];
		vals = '{16'(m), 16'(l), h};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			tracker.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tick(logic a, logic [7:0] tx, logic [3:0] line, logic eob,
			logic miso);
		if (gap_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		tx_byte <= tx;
		select_line <= line;
		end_of_burst <= eob;
		miso_level <= miso;
		do @(posedge clk); while (in_stall);
		tracker.note_tick(a, tx, line, eob, miso);
	endtask

	task automatic send_random_tick();
		send_tick($urandom_range(0, 3) == 0, 8'($urandom), 4'($urandom), 1'($urandom),
			1'($urandom));
	endtask

	// drain: wait until every pin snapshot is back and the pipeline has emptied
	task automatic wait_pins_settled();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pins_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stim_seq
		logic [15:0] h;
		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero half period, full byte on the top line held, start while busy
		gap_on = 1'b1;
		stall_on = 1'b1;
		write_config(2'd0, 1'b0, 16'd0);
		send_tick(1'b0, 8'h00, 4'd0, 1'b1, 1'b1);
		send_tick(1'b1, 8'hFF, 4'd15, 1'b0, 1'b1);
		send_tick(1'b1, 8'h00, 4'd0, 1'b1, 1'b0);
		for (int i = 0; i < 17; i++)
			send_tick(1'b0, 8'hFF, 4'd15, 1'b1, i[0]);

		// other line in mode 3 while the top line stays held; the later line 7 start lands while busy
		wait_pins_settled();
		write_config(2'd3, 1'b1, 16'd1);
		send_tick(1'b1, 8'h00, 4'd0, 1'b1, 1'b0);
		for (int i = 0; i < 15; i++)
			send_random_tick();
		wait_pins_settled();
		gap_on = 1'b0;
		stall_on = 1'b0;
		write_config(2'd3, 1'b1, 16'd4);
		send_tick(1'b1, 8'h5A, 4'd7, 1'b1, 1'b1);
		while (tracker.active)
			send_random_tick();

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_pins_settled();
			h = (ph == 2) ? 16'd0 : 16'($urandom_range(1, 3));
			write_config(2'(ph), 1'($urandom), h);
			// quiet stretches mid-run and through the tail
			gap_on = (ph < PHASES - 2) && (ph % 3 != 1);
			stall_on = gap_on;
			for (int i = 0; i < TICKS_PER_PHASE; i++)
				send_random_tick();
		end

		wait_pins_settled();
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
rtl/core/spim_pkg.sv
rtl/core/spim_front.sv
rtl/core/spim_queue.sv
rtl/core/spim_engine.sv
rtl/core/spi_master_byte_transfer_core.sv
dv/tb_spi_master_byte_transfer_core.sv
